FILE: hdl/fba_pkg.sv
// shared types and constants for the fixed block allocator
package fba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;

    localparam int BSIZE_W    = 13;
    localparam int POOL_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 13;
    localparam int USE_W      = 9;
    localparam int TOTAL_W    = 32;
    localparam int OFFSET_W   = 20;

    localparam logic [LINK_W-1:0] NO_BLOCK = LINK_W'(MAX_BLOCKS);
    localparam logic [USE_W-1:0]  USE_MAX  = '1;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BLOCKS = 1'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic              op;
        logic [12:0]       request_size;
        logic [7:0]        block_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        granted_index;
        logic [19:0]       byte_offset;
        logic [8:0]        in_use;
        logic [8:0]        peak_in_use;
        logic [31:0]       alloc_total;
        logic [31:0]       free_total;
    } t_rsp;

    // link store access, one write or one read per cycle
    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] wdata;
    } t_link_req;

endpackage

FILE: hdl/fba_link_ram.sv
// link store of the free list, single port with registered read data
module fba_link_ram
    import fba_pkg::*;
(
    input  logic              i_clk,
    input  t_link_req         i_req,
    output logic [LINK_W-1:0] o_rdata
);

    logic [LINK_W-1:0] r_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fixed_block_allocator.sv
// fixed block allocator: an allocate that pops the free list adds the S_POP state, other requests stay in S_IDLE
// a result is registered at the edge that accepts the request and shows the cycle after
// a pop holds off the next request for the S_POP state while the new head is read from the link ram
// a free writes its link in the accept cycle; the link ram has no clearing pass
// synchronous active-low reset clears counters, list head and config to defaults
module fixed_block_allocator
    import fba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_req                 i_req,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state              r_state;
    logic [BSIZE_W-1:0]  r_block_size;
    logic [POOL_W-1:0]   r_pool_blocks;
    logic [LINK_W-1:0]   r_fresh, n_fresh;
    logic [LINK_W-1:0]   r_head;
    logic [USE_W-1:0]    r_in_use, n_in_use;
    logic [USE_W-1:0]    r_peak, n_peak;
    logic [TOTAL_W-1:0]  r_alloc_cnt, n_alloc_cnt;
    logic [TOTAL_W-1:0]  r_free_cnt, n_free_cnt;
    logic                r_out_valid;
    t_rsp                r_rsp, n_rsp;

    t_link_req           link_req;
    logic [LINK_W-1:0]   link_rdata;

    logic                accept;
    logic                is_alloc;
    logic                too_big;
    logic                head_valid;
    logic [LINK_W-1:0]   pool_limit;
    logic                can_carve;
    logic                do_pop;
    logic                do_carve;
    logic                got;
    logic                bad_free;
    logic                do_free;
    logic [IDX_W-1:0]    grant_blk;
    logic [IDX_W+BSIZE_W-1:0] product;

    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    assign is_alloc   = (i_req.op == OP_ALLOC);
    assign too_big    = i_req.request_size > r_block_size;
    assign head_valid = r_head < NO_BLOCK;
    assign pool_limit = (int'(r_pool_blocks) > MAX_BLOCKS) ? NO_BLOCK
                                                            : LINK_W'(r_pool_blocks);
    assign can_carve  = r_fresh < pool_limit;
    assign do_pop     = is_alloc && !too_big && head_valid;
    assign do_carve   = is_alloc && !too_big && !head_valid && can_carve;
    assign got        = do_pop || do_carve;
    assign bad_free   = LINK_W'(i_req.block_index) >= r_fresh;
    assign do_free    = !is_alloc && !bad_free;
    assign grant_blk  = head_valid ? r_head[IDX_W-1:0] : r_fresh[IDX_W-1:0];
    assign product    = grant_blk * r_block_size;

    always_comb begin
        n_fresh     = r_fresh;
        n_in_use    = r_in_use;
        n_alloc_cnt = r_alloc_cnt;
        n_free_cnt  = r_free_cnt;
        if (got) begin
            n_alloc_cnt = r_alloc_cnt + 1'b1;
            if (r_in_use < USE_MAX) begin
                n_in_use = r_in_use + 1'b1;
            end
        end
        if (do_carve) begin
            n_fresh = r_fresh + 1'b1;
        end
        if (do_free) begin
            n_free_cnt = r_free_cnt + 1'b1;
            if (r_in_use != '0) begin
                n_in_use = r_in_use - 1'b1;
            end
        end
        n_peak = (n_in_use > r_peak) ? n_in_use : r_peak;

        n_rsp               = '0;
        n_rsp.in_use        = n_in_use;
        n_rsp.peak_in_use   = n_peak;
        n_rsp.alloc_total   = n_alloc_cnt;
        n_rsp.free_total    = n_free_cnt;
        if (is_alloc) begin
            if (too_big) begin
                n_rsp.status = ST_TOO_LARGE;
            end else if (!got) begin
                n_rsp.status = ST_EXHAUSTED;
            end else begin
                n_rsp.status        = ST_DONE;
                n_rsp.granted_index = 8'(grant_blk);
                n_rsp.byte_offset   = product[OFFSET_W-1:0];
            end
        end else begin
            n_rsp.status = bad_free ? ST_BAD_FREE : ST_DONE;
        end
    end

    // free writes the old head as its link, pop reads the head's link
    always_comb begin
        link_req       = '0;
        link_req.we    = accept && do_free;
        link_req.re    = accept && do_pop;
        link_req.addr  = do_free ? i_req.block_index[IDX_W-1:0] : r_head[IDX_W-1:0];
        link_req.wdata = r_head;
    end

    fba_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_req   (link_req),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_size  <= BSIZE_W'(64);
            r_pool_blocks <= POOL_W'(MAX_BLOCKS);
            r_fresh       <= '0;
            r_head        <= NO_BLOCK;
            r_in_use      <= '0;
            r_peak        <= '0;
            r_alloc_cnt   <= '0;
            r_free_cnt    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[BSIZE_W-1:0];
                    REG_POOL_BLOCKS: r_pool_blocks <= i_cfg_data[POOL_W-1:0];
                    default: ;
                endcase
            end

            // a new transfer refills the slot, otherwise it holds while stalled
            r_out_valid <= accept || (r_out_valid && i_stall);

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fresh     <= n_fresh;
                        r_in_use    <= n_in_use;
                        r_peak      <= n_peak;
                        r_alloc_cnt <= n_alloc_cnt;
                        r_free_cnt  <= n_free_cnt;
                        if (do_free) begin
                            r_head <= LINK_W'(i_req.block_index);
                        end
                        if (do_pop) begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_POP: begin
                    r_head  <= (link_rdata > NO_BLOCK) ? NO_BLOCK : link_rdata;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

FILE: hdl/fba_checker.sv
// port level checks for the fixed block allocator, bound to the top level
module fba_checker
    import fba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_stall,
    input  logic o_valid,
    input  logic i_stall,
    input  t_rsp o_rsp
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // every accepted request shows a result on the next cycle
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && !o_stall |=> o_valid)
        else $error("accepted request gave no result");

    // only a successful allocate carries a grant
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_DONE |->
            o_rsp.granted_index == '0 && o_rsp.byte_offset == '0)
        else $error("grant on a refused request");

    // peak never trails the current count
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.peak_in_use >= o_rsp.in_use)
        else $error("peak below in-use");

endmodule

bind fixed_block_allocator fba_checker u_fba_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

FILE: dv/tb_fixed_block_allocator.sv
// testbench for the fixed block allocator: random and directed requests checked against a predictor
module tb_fixed_block_allocator;
    import fba_pkg::*;

    class alloc_tracker;
        logic [BSIZE_W-1:0] blk_bytes;
        logic [POOL_W-1:0]  pool_cap;
        int                 carved;
        int                 head;
        int                 link [MAX_BLOCKS];
        logic [USE_W-1:0]   in_use;
        logic [USE_W-1:0]   peak;
        logic [TOTAL_W-1:0] allocs;
        logic [TOTAL_W-1:0] frees;
        t_rsp               owed_rsp [$];
        int                 fail_cnt;

        function new();
            blk_bytes = BSIZE_W'(64);
            pool_cap  = POOL_W'(256);
            carved    = 0;
            head      = MAX_BLOCKS;
            in_use    = '0;
            peak      = '0;
            allocs    = '0;
            frees     = '0;
            fail_cnt  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_BLOCK_SIZE)
                blk_bytes = data[BSIZE_W-1:0];
            else
                pool_cap = data[POOL_W-1:0];
        endfunction

        // works out the response of one accepted request and queues it
        function t_rsp accept_request(t_req r);
            t_rsp e;
            int   blk;
            int   limit;
            bit   got;
            e        = '0;
            e.status = ST_DONE;
            got      = 1'b0;
            blk      = 0;
            limit    = (pool_cap > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_cap);
            if (r.op == OP_ALLOC) begin
                if (r.request_size > blk_bytes) begin
                    e.status = ST_TOO_LARGE;
                end else if (head < MAX_BLOCKS) begin
                    blk  = head;
                    head = link[blk];
                    got  = 1'b1;
                end else if (carved < limit) begin
                    blk    = carved;
                    carved = carved + 1;
                    got    = 1'b1;
                end else begin
                    e.status = ST_EXHAUSTED;
                end
                if (got) begin
                    allocs = allocs + 1;
                    if (in_use != USE_MAX)
                        in_use = in_use + 1;
                    if (in_use > peak)
                        peak = in_use;
                    e.granted_index = blk[7:0];
                    e.byte_offset   = OFFSET_W'(blk * int'(blk_bytes));
                end
            end else if (r.block_index >= carved) begin
                e.status = ST_BAD_FREE;
            end else begin
                link[r.block_index] = head;
                head  = r.block_index;
                frees = frees + 1;
                if (in_use != 0)
                    in_use = in_use - 1;
            end
            e.in_use      = in_use;
            e.peak_in_use = peak;
            e.alloc_total = allocs;
            e.free_total  = frees;
            owed_rsp.push_back(e);
            return e;
        endfunction

        function void compare_response(t_rsp got);
            t_rsp e;
            if (owed_rsp.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("response with none pending: status %0d index %0d",
                             got.status, got.granted_index);
                return;
            end
            e = owed_rsp.pop_front();
            if (got.status !== e.status || got.granted_index !== e.granted_index ||
                got.byte_offset !== e.byte_offset || got.in_use !== e.in_use ||
                got.peak_in_use !== e.peak_in_use || got.alloc_total !== e.alloc_total ||
                got.free_total !== e.free_total) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("mismatch exp: st %0d idx %0d off %0d use %0d peak %0d al %0d fr %0d",
                             e.status, e.granted_index, e.byte_offset, e.in_use,
                             e.peak_in_use, e.alloc_total, e.free_total);
                    $display("         act: st %0d idx %0d off %0d use %0d peak %0d al %0d fr %0d",
                             got.status, got.granted_index, got.byte_offset, got.in_use,
                             got.peak_in_use, got.alloc_total, got.free_total);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_req                 i_req       = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_rsp                 o_rsp;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    alloc_tracker sb = new();
    int           held [$];
    int           sender_pct   = 16;
    int           receiver_pct = 57;
    logic         hold_go      = 1'b0;
    logic         hold_done    = 1'b0;
    int           hold_left    = 0;

    fixed_block_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // response side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.compare_response(o_rsp);
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= 100;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_pct);
        end
    end

    task automatic offer(input logic op, input int size, input int idx);
        t_req r;
        t_rsp e;
        int   k;
        r.op           = op;
        r.request_size = size[12:0];
        r.block_index  = idx[7:0];
        while ($urandom_range(99) < sender_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        e = sb.accept_request(r);
        if (e.status == ST_DONE) begin
            if (op == OP_ALLOC) begin
                held.push_back(e.granted_index);
            end else begin
                for (k = 0; k < held.size(); k++) begin
                    if (held[k] == idx) begin
                        held.delete(k);
                        break;
                    end
                end
            end
        end
    endtask

    // drain outstanding transfers, then write both registers
    task automatic reconfigure(input int bytes, input int blocks);
        i_valid <= 1'b0;
        while (sb.owed_rsp.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_BLOCK_SIZE;
        i_cfg_data  <= CFG_W'(bytes);
        @(posedge i_clk);
        sb.write_reg(REG_BLOCK_SIZE, CFG_W'(bytes));
        i_cfg_index <= REG_POOL_BLOCKS;
        i_cfg_data  <= CFG_W'(blocks);
        @(posedge i_clk);
        sb.write_reg(REG_POOL_BLOCKS, CFG_W'(blocks));
        i_cfg_we <= 1'b0;
    endtask

    // frees target blocks actually held, or blocks not yet carved, so the free list never loops by accident
    task automatic random_item(input int alloc_pct, input int free_pct);
        int pick;
        int bs;
        pick = $urandom_range(99);
        bs   = sb.blk_bytes;
        if (pick < alloc_pct || (pick < alloc_pct + free_pct && held.size() == 0)) begin
            if ($urandom_range(99) < 85)
                offer(OP_ALLOC, $urandom_range(bs), $urandom_range(255));
            else
                offer(OP_ALLOC, $urandom_range(8191), $urandom_range(255));
        end else if (pick < alloc_pct + free_pct) begin
            offer(OP_FREE, $urandom_range(8191), held[$urandom_range(held.size() - 1)]);
        end else if (sb.carved < MAX_BLOCKS) begin
            offer(OP_FREE, $urandom_range(8191), $urandom_range(255, sb.carved));
        end else begin
            offer(OP_ALLOC, $urandom_range(8191), $urandom_range(255));
        end
    endtask

    initial begin
        int dup;
        int tail;
        int guard;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: boundaries of size and index, exhaustion, shrunk and oversized pool
        offer(OP_FREE, 0, 0);
        offer(OP_ALLOC, 0, 255);
        offer(OP_ALLOC, 64, 0);
        offer(OP_ALLOC, 65, 0);
        offer(OP_ALLOC, 4096, 0);
        offer(OP_ALLOC, 8191, 0);
        offer(OP_FREE, 8191, 255);
        offer(OP_FREE, 0, 2);
        offer(OP_FREE, 0, 1);
        offer(OP_ALLOC, 1, 0);
        offer(OP_FREE, 0, 0);
        offer(OP_FREE, 0, 1);
        offer(OP_ALLOC, 5, 0);
        offer(OP_ALLOC, 5, 0);
        reconfigure(1, 3);
        offer(OP_ALLOC, 1, 0);
        offer(OP_ALLOC, 2, 0);
        offer(OP_ALLOC, 0, 0);
        offer(OP_FREE, 0, 2);
        offer(OP_ALLOC, 1, 0);
        reconfigure(4096, 1);
        offer(OP_ALLOC, 4096, 0);
        offer(OP_FREE, 0, 2);
        offer(OP_ALLOC, 4096, 0);
        reconfigure(4096, 511);
        offer(OP_ALLOC, 4095, 0);

        reconfigure(64, 8);
        repeat (80) random_item(55, 35);
        reconfigure(1, 16);
        repeat (80) random_item(55, 35);

        sender_pct   = 57;
        receiver_pct <= 16;
        reconfigure($urandom_range(4096, 1), 256);
        repeat (80) random_item(60, 30);
        reconfigure(4096, 511);
        repeat (80) random_item(65, 25);

        sender_pct   = 0;
        receiver_pct <= 0;
        reconfigure(8191, 1);
        hold_go <= 1'b1;
        repeat (80) random_item(70, 25);

        // a double free closes the list on itself, so every later allocate that fits succeeds
        // and the in-use count climbs to its limit
        reconfigure($urandom_range(4096, 1), 256);
        offer(OP_ALLOC, 0, 0);
        dup = held[held.size() - 1];
        offer(OP_FREE, 0, dup);
        offer(OP_FREE, 0, dup);
        tail  = 0;
        guard = 0;
        while (tail < 30 && guard < 1000) begin
            random_item(92, 6);
            guard++;
            if (sb.in_use == USE_MAX)
                tail++;
        end

        i_valid <= 1'b0;
        while (sb.owed_rsp.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_cnt == 0 && sb.owed_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
